// ===== hw/rtl/gf2pm_pkg.sv =====
package gf2pm_pkg;

   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned HIGH_BITS = 63;
   localparam int unsigned DATA_BITS = 128;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_QUOT = 2'd1,
      OP_REM  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic divide;
   } alu_ctl_type;

endpackage

// ===== hw/rtl/gf2_polynomial_mul_div_mod.sv =====
// Polynomial arithmetic over GF(2): carryless multiply, quotient and remainder of the
// low POLY_BITS bits of two operands, one result transaction per request transaction.
// A request is worked through by a single shift-and-xor unit that handles one
// coefficient per cycle; the result of multiply, quotient or remainder is then loaded
// into the output register. No new request is taken until the current one has been
// loaded there. A zero divisor or operation code 3 skips the loop. The result register
// lets the next request be accepted while the previous result waits to be taken.
module gf2_polynomial_mul_div_mod #(
   parameter int unsigned POLY_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // operand_a, operand_b
   input  logic [gf2pm_pkg::DATA_BITS-1:0] req_tdata,
   // req_type
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // result_low, result_high, one zero pad bit
   output logic [gf2pm_pkg::DATA_BITS-1:0] rsp_tdata,
   // divide_by_zero
   output logic [0:0]                     rsp_tuser
);
   import gf2pm_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(POLY_BITS);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   op_type                op_ff, op_in;
   logic                  dz_ff, dz_in;
   logic                  zero_ff, zero_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic                  rsp_dz_ff, rsp_dz_in;

   logic                  accept;
   logic                  load_out;
   op_type                req_op;
   logic [POLY_BITS-1:0]  a_in;
   logic [POLY_BITS-1:0]  b_in;
   alu_ctl_type           ctl;
   logic [2*POLY_BITS-1:0] acc;
   logic [POLY_BITS-1:0]  quot;
   logic [DATA_BITS-1:0]  prod_ext;
   logic [DATA_BITS-1:0]  result;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign a_in       = req_tdata[POLY_BITS-1:0];
   assign b_in       = req_tdata[WORD_BITS +: POLY_BITS];
   assign load_out   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign ctl.load   = accept;
   assign ctl.step   = (state_ff == ST_RUN);
   assign ctl.divide = (op_ff != OP_MUL);

   gf2pm_alu #(
      .POLY_BITS(POLY_BITS)
   ) u_alu (
      .clock (clock),
      .ctl   (ctl),
      .a_in  (a_in),
      .b_in  (b_in),
      .acc   (acc),
      .quot  (quot)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      dz_in    = dz_ff;
      zero_in  = zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               dz_in    = ((req_op == OP_QUOT) || (req_op == OP_REM)) && (b_in == '0);
               zero_in  = dz_in || (req_op == OP_NONE);
               cnt_in   = CNT_BITS'(POLY_BITS - 1);
               state_in = zero_in ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      prod_ext = DATA_BITS'(acc);
      result   = '0;
      if (!zero_ff) begin
         case (op_ff)
            OP_MUL:  result = {1'b0, prod_ext[WORD_BITS+HIGH_BITS-1:0]};
            OP_QUOT: result = {{WORD_BITS{1'b0}}, WORD_BITS'(quot)};
            OP_REM:  result = {{WORD_BITS{1'b0}}, WORD_BITS'(acc[POLY_BITS-1:0])};
            default: result = '0;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_dz_in    = rsp_dz_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
         rsp_dz_in    = dz_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      dz_ff       <= dz_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
      rsp_dz_ff   <= rsp_dz_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_dz_ff;

endmodule

// ===== hw/rtl/gf2pm_alu.sv =====
module gf2pm_alu #(
   parameter int unsigned POLY_BITS = 64
) (
   input  logic                     clock,
   input  gf2pm_pkg::alu_ctl_type   ctl,
   input  logic [POLY_BITS-1:0]     a_in,
   input  logic [POLY_BITS-1:0]     b_in,
   output logic [2*POLY_BITS-1:0]   acc,
   output logic [POLY_BITS-1:0]     quot
);
   import gf2pm_pkg::*;

   logic [2*POLY_BITS-1:0] acc_ff, acc_in;
   logic [POLY_BITS-1:0]   quot_ff, quot_in;
   logic [POLY_BITS-1:0]   a_ff, a_in_next;
   logic [POLY_BITS-1:0]   b_ff, b_in_next;
   logic [POLY_BITS-1:0]   top_ff, top_in;
   logic [POLY_BITS-1:0]   smear;
   logic [2*POLY_BITS-1:0] shifted;
   logic                   hit;

   // One-hot mask of the divisor's leading coefficient.
   always_comb begin
      smear = b_in >> 1;
      for (int k = 1; k < POLY_BITS; k = k * 2) begin
         smear = smear | (smear >> k);
      end
      top_in = b_in & ~smear;
   end

   // The shared shift-and-xor step serves both the product and the long division.
   always_comb begin
      shifted = {acc_ff[2*POLY_BITS-2:0], ctl.divide ? a_ff[POLY_BITS-1] : 1'b0};
      hit     = ctl.divide ? (|(shifted[POLY_BITS-1:0] & top_ff)) : a_ff[POLY_BITS-1];
      acc_in    = acc_ff;
      quot_in   = quot_ff;
      a_in_next = a_ff;
      b_in_next = b_ff;
      if (ctl.load) begin
         acc_in    = '0;
         quot_in   = '0;
         a_in_next = a_in;
         b_in_next = b_in;
      end else if (ctl.step) begin
         acc_in    = shifted ^ (hit ? {{POLY_BITS{1'b0}}, b_ff} : '0);
         quot_in   = {quot_ff[POLY_BITS-2:0], hit};
         a_in_next = {a_ff[POLY_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      quot_ff <= quot_in;
      a_ff    <= a_in_next;
      b_ff    <= b_in_next;
      if (ctl.load) begin
         top_ff <= top_in;
      end
   end

   assign acc  = acc_ff;
   assign quot = quot_ff;

endmodule

// ===== hw/rtl/gf2pm_checker.sv =====
module gf2pm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // A result is never shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // An accepted request leaves the block not ready in the cycle after.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted on consecutive cycles");

   // A division by zero returns all zero coefficients.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("nonzero result with divide by zero");

   // The pad bit above the high word is always clear.
   a_pad_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[127])
      else $error("pad bit set in result");

endmodule

bind gf2_polynomial_mul_div_mod gf2pm_checker u_checker (.*);

// ===== tb/gf2_polynomial_mul_div_mod_checker.sv =====
module gf2_polynomial_mul_div_mod_checker #(
   parameter int unsigned POLY_BITS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // operand_a, operand_b
   input  logic [gf2pm_pkg::DATA_BITS-1:0] req_tdata,
   // req_type
   input  logic [1:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_low, result_high, one zero pad bit
   input  logic [gf2pm_pkg::DATA_BITS-1:0] rsp_tdata,
   // divide_by_zero
   input  logic [0:0]                      rsp_tuser,
   output int unsigned                     error_count,
   output int unsigned                     pending_count,
   output int unsigned                     result_count
);

   typedef struct packed {
      logic [gf2pm_pkg::WORD_BITS-1:0] low;
      logic [gf2pm_pkg::HIGH_BITS-1:0] high;
      logic                            div_zero;
   } gf2_result_t;

   gf2_result_t expected_results[$];
   int unsigned mismatches;
   int unsigned results_seen;

   function automatic int unsigned degree_of(input logic [63:0] p);
      int unsigned d;
      d = 0;
      for (int i = 0; i < 64; i++) begin
         if (p[i]) begin
            d = i;
         end
      end
      return d;
   endfunction

   function automatic gf2_result_t gf2_arith(input gf2pm_pkg::op_type op,
                                             input logic [63:0] a_in,
                                             input logic [63:0] b_in);
      logic [63:0] mask;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] low;
      logic [63:0] high;
      logic [63:0] quo;
      logic [63:0] rem;
      int unsigned db;
      int unsigned s;
      gf2_result_t r;
      mask = {64{1'b1}} >> (64 - POLY_BITS);
      a    = a_in & mask;
      b    = b_in & mask;
      low  = '0;
      high = '0;
      r    = '0;
      case (op)
         gf2pm_pkg::OP_MUL: begin
            for (int i = 0; i < 64; i++) begin
               if (a[i]) begin
                  low = low ^ (b << i);
                  if (i != 0) begin
                     high = high ^ (b >> (64 - i));
                  end
               end
            end
         end
         gf2pm_pkg::OP_QUOT, gf2pm_pkg::OP_REM: begin
            if (b == '0) begin
               r.div_zero = 1'b1;
            end else begin
               quo = '0;
               rem = a;
               db  = degree_of(b);
               while (rem != '0 && degree_of(rem) >= db) begin
                  s      = degree_of(rem) - db;
                  rem    = rem ^ (b << s);
                  quo[s] = 1'b1;
               end
               low = (op == gf2pm_pkg::OP_QUOT) ? quo : rem;
            end
         end
         default: begin
         end
      endcase
      r.low  = low;
      r.high = high[gf2pm_pkg::HIGH_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : track_results
      gf2_result_t want;
      gf2_result_t got;
      if (reset) begin
         expected_results.delete();
         mismatches   = 0;
         results_seen = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(gf2_arith(gf2pm_pkg::op_type'(req_tuser),
                                                 req_tdata[63:0], req_tdata[127:64]));
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.low      = rsp_tdata[63:0];
            got.high     = rsp_tdata[126:64];
            got.div_zero = rsp_tuser[0];
            if (expected_results.size() == 0) begin
               $error("result transaction arrived with no request outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (got.low !== want.low) begin
                  $error("result_low mismatch: expected %h, actual %h", want.low, got.low);
                  mismatches++;
               end
               if (got.high !== want.high) begin
                  $error("result_high mismatch: expected %h, actual %h",
                         want.high, got.high);
                  mismatches++;
               end
               if (got.div_zero !== want.div_zero) begin
                  $error("divide_by_zero mismatch: expected %b, actual %b",
                         want.div_zero, got.div_zero);
                  mismatches++;
               end
               if (rsp_tdata[127] !== 1'b0) begin
                  $error("pad bit mismatch: expected 0, actual %b", rsp_tdata[127]);
                  mismatches++;
               end
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_results.size();
      result_count  <= results_seen;
   end

endmodule

// ===== tb/tb_gf2_polynomial_mul_div_mod.sv =====
module tb_gf2_polynomial_mul_div_mod;

   localparam int unsigned POLY_BITS      = 64;
   localparam int unsigned CLOCK_PERIOD   = 8;
   localparam int unsigned IDLE_PCT       = 27;
   localparam int unsigned RANDOM_ITEMS   = 950;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned TIMEOUT_CYCLES = 600000;

   localparam logic [63:0] ALL_ONES = {64{1'b1}};
   localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [gf2pm_pkg::DATA_BITS-1:0] req_tdata;
   logic [1:0]                      req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [gf2pm_pkg::DATA_BITS-1:0] rsp_tdata;
   logic [0:0]                      rsp_tuser;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned result_count;

   logic        quiet;
   logic        hold_rsp;
   int unsigned op_sent[4];
   int unsigned item_idx;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   gf2_polynomial_mul_div_mod #(
      .POLY_BITS(POLY_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   gf2_polynomial_mul_div_mod_checker #(
      .POLY_BITS(POLY_BITS)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .error_count  (error_count),
      .pending_count(pending_count),
      .result_count (result_count)
   );

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] random_operand();
      int unsigned kind;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         return '0;
      end else if (kind == 1) begin
         return 64'd1;
      end else if (kind <= 3) begin
         return 64'd1 << $urandom_range(0, 63);
      end else if (kind <= 11) begin
         return random_word() >> $urandom_range(0, 63);
      end
      return random_word();
   endfunction

   function automatic gf2pm_pkg::op_type random_op();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         return gf2pm_pkg::OP_MUL;
      end else if (pick < 60) begin
         return gf2pm_pkg::OP_QUOT;
      end else if (pick < 92) begin
         return gf2pm_pkg::OP_REM;
      end
      return gf2pm_pkg::OP_NONE;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_request(input gf2pm_pkg::op_type op, input logic [63:0] a,
                               input logic [63:0] b);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {b, a};
      req_tuser  = op;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
      op_sent[op]++;
   endtask

   initial begin : rsp_side
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready = quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("gf2_polynomial_mul_div_mod verification failed");
      $finish;
   end

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = gf2pm_pkg::OP_MUL;
      quiet      = 1'b0;
      hold_rsp   = 1'b0;
      for (int i = 0; i < 4; i++) begin
         op_sent[i] = 0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(gf2pm_pkg::OP_MUL, '0, ALL_ONES);
      send_request(gf2pm_pkg::OP_MUL, ALL_ONES, ALL_ONES);
      send_request(gf2pm_pkg::OP_MUL, TOP_BIT, TOP_BIT);
      send_request(gf2pm_pkg::OP_MUL, 64'd1, random_word());
      send_request(gf2pm_pkg::OP_MUL, ALL_ONES, '0);
      send_request(gf2pm_pkg::OP_MUL, random_word(), random_word());
      send_request(gf2pm_pkg::OP_QUOT, random_word(), '0);
      send_request(gf2pm_pkg::OP_REM, random_word(), '0);
      send_request(gf2pm_pkg::OP_QUOT, '0, '0);
      send_request(gf2pm_pkg::OP_QUOT, ALL_ONES, 64'd1);
      send_request(gf2pm_pkg::OP_REM, ALL_ONES, 64'd1);
      send_request(gf2pm_pkg::OP_QUOT, 64'h5, 64'h100);
      send_request(gf2pm_pkg::OP_REM, 64'h35, 64'h100);
      send_request(gf2pm_pkg::OP_QUOT, ALL_ONES, ALL_ONES);
      send_request(gf2pm_pkg::OP_REM, ALL_ONES, 64'h3);
      send_request(gf2pm_pkg::OP_QUOT, TOP_BIT, 64'h1B);
      send_request(gf2pm_pkg::OP_REM, TOP_BIT, 64'h1B);
      send_request(gf2pm_pkg::OP_QUOT, '0, 64'h7);
      send_request(gf2pm_pkg::OP_REM, random_word(), TOP_BIT);
      send_request(gf2pm_pkg::OP_QUOT, random_word(), random_word() >> 40);
      send_request(gf2pm_pkg::OP_NONE, ALL_ONES, ALL_ONES);
      send_request(gf2pm_pkg::OP_NONE, random_word(), '0);

      for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
         if (item_idx == 300) begin
            hold_rsp = 1'b1;
         end
         quiet = (item_idx >= 600 && item_idx < 700);
         send_request(random_op(), random_operand(), random_operand());
      end
      req_tvalid = 1'b0;
      quiet      = 1'b0;

      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (2 * POLY_BITS) @(posedge clock);

      $display("Run covered %0d multiply, %0d quotient, %0d remainder, %0d unused-code requests,",
               op_sent[gf2pm_pkg::OP_MUL], op_sent[gf2pm_pkg::OP_QUOT],
               op_sent[gf2pm_pkg::OP_REM], op_sent[gf2pm_pkg::OP_NONE]);
      $display("with random idling, a %0d-cycle result stall, and %0d results compared.",
               HOLD_CYCLES, result_count);
      if (error_count == 0) begin
         $display("gf2_polynomial_mul_div_mod verification clean");
      end else begin
         $display("gf2_polynomial_mul_div_mod verification failed");
      end
      $finish;
   end

endmodule

// ===== gf2_polynomial_mul_div_mod.f =====
hw/rtl/gf2pm_pkg.sv
hw/rtl/gf2pm_alu.sv
hw/rtl/gf2_polynomial_mul_div_mod.sv
hw/rtl/gf2pm_checker.sv
tb/gf2_polynomial_mul_div_mod_checker.sv
tb/tb_gf2_polynomial_mul_div_mod.sv
